// ----- sv/i2c_master_transfer_sequencer_top_macros.svh -----
// Assertion macros for the I2C master transfer sequencer.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_TOP_MACROS_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_TOP_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define I2CMTS_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("i2cmts: invariant violated");

// Same-cycle implication.
`define I2CMTS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2cmts: implication violated");

// Next-cycle implication.
`define I2CMTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2cmts: next-cycle check violated");

`endif

// ----- sv/i2cmts_pkg.sv -----
// Types, codes and helpers shared by the I2C master transfer sequencer.
`timescale 1ns / 1ps
package i2cmts_pkg;

  localparam int unsigned MAX_BYTES   = 1024;
  localparam int unsigned CHUNK_LIMIT = 255;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned CNT_W       = 11;

  localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_BYTES);
  localparam logic [CNT_W-1:0] CHUNK_CNT = CNT_W'(CHUNK_LIMIT);

  // event codes
  localparam logic [3:0] KIND_LOAD   = 4'd0;
  localparam logic [3:0] KIND_START  = 4'd1;
  localparam logic [3:0] KIND_PROBE  = 4'd2;
  localparam logic [3:0] KIND_TXREQ  = 4'd3;
  localparam logic [3:0] KIND_RELOAD = 4'd4;
  localparam logic [3:0] KIND_CHUNK  = 4'd5;
  localparam logic [3:0] KIND_RXBYTE = 4'd6;
  localparam logic [3:0] KIND_STOP   = 4'd7;
  localparam logic [3:0] KIND_NACK   = 4'd8;

  // bus commands
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;
  localparam logic [1:0] CMD_CHUNK = 2'd3;

  // byte actions
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_SEND  = 2'd1;
  localparam logic [1:0] ACT_STORE = 2'd2;

  typedef struct packed {
    logic [3:0]       kind;
    logic [7:0]       data_in;
    logic [6:0]       target_address;
    logic [CNT_W-1:0] write_count;
    logic [CNT_W-1:0] read_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       command;
    logic             read_direction;
    logic [7:0]       chunk_bytes;
    logic             reload;
    logic             auto_end;
    logic [6:0]       bus_address;
    logic [1:0]       byte_action;
    logic [7:0]       data_out;
    logic [IDX_W-1:0] byte_index;
    logic             done_res;
    logic             failed;
    logic [CNT_W-1:0] received_total;
  } out_item_t;

  typedef struct packed {
    logic [7:0] bytes;
    logic       reload;
  } chunk_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
    return (c > MAX_CNT) ? MAX_CNT : c;
  endfunction

  // Chunk count for the bytes still left; reload when more than one chunk remains.
  function automatic chunk_t chunk_of(input logic [CNT_W-1:0] left);
    chunk_t ch;
    if (left > CHUNK_CNT) begin
      ch.bytes  = CHUNK_CNT[7:0];
      ch.reload = 1'b1;
    end else begin
      ch.bytes  = left[7:0];
      ch.reload = 1'b0;
    end
    return ch;
  endfunction

endpackage

// ----- sv/i2c_master_transfer_sequencer_top.sv -----
// Top level of the I2C master transfer sequencer.
`timescale 1ns / 1ps
// One bus event or buffer load is accepted every cycle while in_ready is high;
// its result beat appears in the output register on the next cycle. The write
// bytes sit in a 1024 x 8 synchronous RAM with one write and one read port, so
// a transmit request's byte comes out of the RAM read register with its result
// beat. Input ready drops only while a result beat waits at the output. The buffer
// has no reset: sending a byte that was never loaded returns an undefined value.
`include "i2c_master_transfer_sequencer_top_macros.svh"
module i2c_master_transfer_sequencer_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  i2cmts_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2cmts_pkg::out_item_t out_data
);

  logic [7:0] mem [i2cmts_pkg::MAX_BYTES];
  logic [7:0] mem_q_r;

  logic [i2cmts_pkg::CNT_W-1:0] load_pointer_r, load_pointer_nxt;
  logic [i2cmts_pkg::CNT_W-1:0] write_total_r, write_total_nxt;
  logic [i2cmts_pkg::CNT_W-1:0] read_total_r, read_total_nxt;
  logic [i2cmts_pkg::CNT_W-1:0] write_position_r, write_position_nxt;
  logic [i2cmts_pkg::CNT_W-1:0] read_position_r, read_position_nxt;
  logic                         in_read_phase_r, in_read_phase_nxt;
  logic                         nack_latched_r, nack_latched_nxt;
  logic                         busy_r, busy_nxt;
  logic [6:0]                   slave_addr_r, slave_addr_nxt;

  logic                  out_valid_r;
  logic                  use_mem_r;
  i2cmts_pkg::out_item_t res_r, res_nxt;
  logic                  use_mem_nxt;

  logic                         accept;
  logic                         mem_we;
  logic                         mem_re;
  logic [i2cmts_pkg::CNT_W-1:0] wt_clamped;
  logic [i2cmts_pkg::CNT_W-1:0] rt_clamped;
  logic [i2cmts_pkg::CNT_W-1:0] rp_inc;
  i2cmts_pkg::chunk_t           ch;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  assign wt_clamped = i2cmts_pkg::clamp_count(in_data.write_count);
  assign rt_clamped = i2cmts_pkg::clamp_count(in_data.read_count);
  assign rp_inc     = read_position_r + 1'b1;

  always_comb begin
    load_pointer_nxt   = load_pointer_r;
    write_total_nxt    = write_total_r;
    read_total_nxt     = read_total_r;
    write_position_nxt = write_position_r;
    read_position_nxt  = read_position_r;
    in_read_phase_nxt  = in_read_phase_r;
    nack_latched_nxt   = nack_latched_r;
    busy_nxt           = busy_r;
    slave_addr_nxt     = slave_addr_r;
    res_nxt            = '0;
    use_mem_nxt        = 1'b0;
    mem_we             = 1'b0;
    mem_re             = 1'b0;
    ch                 = '0;
    unique case (in_data.kind)
      i2cmts_pkg::KIND_LOAD: begin
        if (load_pointer_r < i2cmts_pkg::MAX_CNT) begin
          mem_we           = accept;
          load_pointer_nxt = load_pointer_r + 1'b1;
        end
      end
      i2cmts_pkg::KIND_START: begin
        if (!busy_r) begin
          busy_nxt           = 1'b1;
          nack_latched_nxt   = 1'b0;
          load_pointer_nxt   = '0;
          write_position_nxt = '0;
          read_position_nxt  = '0;
          slave_addr_nxt     = in_data.target_address;
          write_total_nxt    = wt_clamped;
          read_total_nxt     = rt_clamped;
          res_nxt.command     = i2cmts_pkg::CMD_START;
          res_nxt.bus_address = in_data.target_address;
          if (wt_clamped != '0) begin
            in_read_phase_nxt = 1'b0;
            ch = i2cmts_pkg::chunk_of(wt_clamped);
          end else if (rt_clamped != '0) begin
            in_read_phase_nxt = 1'b1;
            ch = i2cmts_pkg::chunk_of(rt_clamped);
          end else begin
            in_read_phase_nxt = 1'b0;
          end
          res_nxt.chunk_bytes = ch.bytes;
          res_nxt.reload      = ch.reload;
        end
      end
      i2cmts_pkg::KIND_PROBE: begin
        if (!busy_r) begin
          busy_nxt           = 1'b1;
          nack_latched_nxt   = 1'b0;
          load_pointer_nxt   = '0;
          write_position_nxt = '0;
          read_position_nxt  = '0;
          write_total_nxt    = '0;
          read_total_nxt     = '0;
          in_read_phase_nxt  = 1'b0;
          slave_addr_nxt     = in_data.target_address;
          res_nxt.command     = i2cmts_pkg::CMD_START;
          res_nxt.auto_end    = 1'b1;
          res_nxt.bus_address = in_data.target_address;
        end
      end
      i2cmts_pkg::KIND_TXREQ: begin
        if (busy_r && !in_read_phase_r && write_position_r < write_total_r) begin
          mem_re              = accept;
          use_mem_nxt         = 1'b1;
          res_nxt.byte_action = i2cmts_pkg::ACT_SEND;
          res_nxt.byte_index  = write_position_r[i2cmts_pkg::IDX_W-1:0];
          write_position_nxt  = write_position_r + 1'b1;
        end
      end
      i2cmts_pkg::KIND_RELOAD: begin
        if (busy_r) begin
          ch = i2cmts_pkg::chunk_of(in_read_phase_r ? (read_total_r - read_position_r)
                                                    : (write_total_r - write_position_r));
          res_nxt.command     = i2cmts_pkg::CMD_CHUNK;
          res_nxt.chunk_bytes = ch.bytes;
          res_nxt.reload      = ch.reload;
        end
      end
      i2cmts_pkg::KIND_CHUNK: begin
        if (busy_r) begin
          if (!in_read_phase_r && read_total_r != '0) begin
            in_read_phase_nxt   = 1'b1;
            ch                  = i2cmts_pkg::chunk_of(read_total_r);
            res_nxt.command     = i2cmts_pkg::CMD_START;
            res_nxt.bus_address = slave_addr_r;
            res_nxt.chunk_bytes = ch.bytes;
            res_nxt.reload      = ch.reload;
          end else begin
            res_nxt.command = i2cmts_pkg::CMD_STOP;
          end
        end
      end
      i2cmts_pkg::KIND_RXBYTE: begin
        if (busy_r && in_read_phase_r && read_position_r < read_total_r) begin
          res_nxt.byte_action = i2cmts_pkg::ACT_STORE;
          res_nxt.data_out    = in_data.data_in;
          res_nxt.byte_index  = read_position_r[i2cmts_pkg::IDX_W-1:0];
          read_position_nxt   = rp_inc;
          if (rp_inc == read_total_r) res_nxt.command = i2cmts_pkg::CMD_STOP;
        end
      end
      i2cmts_pkg::KIND_STOP: begin
        if (busy_r) begin
          busy_nxt               = 1'b0;
          res_nxt.done_res       = 1'b1;
          res_nxt.failed         = nack_latched_r;
          res_nxt.received_total = nack_latched_r ? '0 : read_position_r;
        end
      end
      i2cmts_pkg::KIND_NACK: begin
        if (busy_r) nack_latched_nxt = 1'b1;
      end
      default: begin
      end
    endcase
    res_nxt.read_direction = in_read_phase_nxt;
  end

  // write buffer: one write port for loads, one registered read for transmits
  always_ff @(posedge clk) begin
    if (mem_we) mem[load_pointer_r[i2cmts_pkg::IDX_W-1:0]] <= in_data.data_in;
    if (mem_re) mem_q_r <= mem[write_position_r[i2cmts_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pointer_r   <= '0;
      write_total_r    <= '0;
      read_total_r     <= '0;
      write_position_r <= '0;
      read_position_r  <= '0;
      in_read_phase_r  <= 1'b0;
      nack_latched_r   <= 1'b0;
      busy_r           <= 1'b0;
      slave_addr_r     <= '0;
      out_valid_r      <= 1'b0;
      use_mem_r        <= 1'b0;
    end else begin
      if (accept) begin
        load_pointer_r   <= load_pointer_nxt;
        write_total_r    <= write_total_nxt;
        read_total_r     <= read_total_nxt;
        write_position_r <= write_position_nxt;
        read_position_r  <= read_position_nxt;
        in_read_phase_r  <= in_read_phase_nxt;
        nack_latched_r   <= nack_latched_nxt;
        busy_r           <= busy_nxt;
        slave_addr_r     <= slave_addr_nxt;
        use_mem_r        <= use_mem_nxt;
        out_valid_r      <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res_r <= res_nxt;
  end

  // sent bytes come straight from the RAM read register
  always_comb begin
    out_data = res_r;
    if (use_mem_r) out_data.data_out = mem_q_r;
  end

  `I2CMTS_ASSERT_ALWAYS(a_load_ptr_range, load_pointer_r <= i2cmts_pkg::MAX_CNT)
  `I2CMTS_ASSERT_ALWAYS(a_wpos_range, write_position_r <= write_total_r)
  `I2CMTS_ASSERT_ALWAYS(a_rpos_range, read_position_r <= read_total_r)
  `I2CMTS_ASSERT_NEXT(a_stop_clears_busy, accept && in_data.kind == i2cmts_pkg::KIND_STOP, !busy_r)
  `I2CMTS_ASSERT_IMPL(a_mem_only_send, out_valid_r && use_mem_r, res_r.byte_action == i2cmts_pkg::ACT_SEND)

endmodule
